// ----- hdl/split_frame_reassembler_macros.svh -----
// ----------------------------------------------------------------------------
// split_frame_reassembler_macros
// assertion helpers shared by the reassembler rtl
// ----------------------------------------------------------------------------
`ifndef SPLIT_FRAME_REASSEMBLER_MACROS_SVH
`define SPLIT_FRAME_REASSEMBLER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfr check failed");
// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfr check failed");
`else
`define SFR_ASSERT_NOW(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants and codes of the split frame reassembler
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int STORE_DEPTH_DEF = 512;

   localparam int DATA_W       = 8;
   localparam int MAXLEN_W     = 10;
   localparam int TIME_W       = 32;
   localparam int COUNT_W      = 32;
   localparam int READ_INDEX_W = 9;
   localparam int EVENT_W      = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;

   // result event codes
   localparam logic [EVENT_W-1:0] EV_BUSY     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_HELD     = 3'd1;
   localparam logic [EVENT_W-1:0] EV_COMPLETE = 3'd2;
   localparam logic [EVENT_W-1:0] EV_DROPPED  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_READ     = 3'd4;
   localparam logic [EVENT_W-1:0] EV_OVERFLOW = 3'd5;

   // request function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_JOIN_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_FLAG_MASK = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_MASK        = 2'd3;

   // register reset values
   localparam logic [MAXLEN_W-1:0] JOIN_LIMIT_RST      = 10'd512;
   localparam logic [TIME_W-1:0]   TIMEOUT_MS_RST      = 32'd1000;
   localparam logic [DATA_W-1:0]   SPLIT_FLAG_MASK_RST = 8'd1;
   localparam logic [DATA_W-1:0]   SEQ_MASK_RST        = 8'd240;

endpackage

// ----- hdl/split_frame_reassembler.sv -----
// ----------------------------------------------------------------------------
// split_frame_reassembler
// joins split radio frames byte by byte and serves the assembled packet
// ----------------------------------------------------------------------------
// One byte transaction is taken every clock cycle while req_stall is low, with
// no gaps between headers, payload bytes and store reads. Each transaction
// returns one result, which passes through the read stage, covering the
// registered read of the packet store (a single synchronous memory of
// STORE_DEPTH bytes), and then through the output register. Frame state,
// counters and the store write all settle in the cycle a byte is taken, so
// a read right after a payload byte already sees that byte. Results queue
// in the read stage and the output register while rsp_stall is high; the
// request side stalls only once both are full. The store needs no clearing
// after reset.
module split_frame_reassembler import sfr_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [DATA_W-1:0]       req_data_byte,
   input  logic                    req_first_of_frame,
   input  logic                    req_last_of_frame,
   input  logic [TIME_W-1:0]       req_now_ms,
   input  logic [READ_INDEX_W-1:0] req_read_index,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [EVENT_W-1:0]      rsp_event_res,
   output logic                    rsp_stale,
   output logic [MAXLEN_W-1:0]     rsp_stale_size,
   output logic [MAXLEN_W-1:0]     rsp_packet_len,
   output logic [DATA_W-1:0]       rsp_seq_tag,
   output logic [DATA_W-1:0]       rsp_read_byte,
   output logic [COUNT_W-1:0]      rsp_dropped_count,
   output logic [COUNT_W-1:0]      rsp_completed_count
);

`include "split_frame_reassembler_macros.svh"

   localparam int CNT_W  = $clog2(STORE_DEPTH + 2);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int POS_W  = CNT_W + 1;
   localparam int CMP_W  = (POS_W > MAXLEN_W) ? POS_W : MAXLEN_W;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_HOLD  = 2'd1,
      MODE_JOIN  = 2'd2,
      MODE_IDLE  = 2'd3
   } mode_type;

   // configuration registers
   logic [MAXLEN_W-1:0] join_limit_ff;
   logic [TIME_W-1:0]   timeout_ms_ff;
   logic [DATA_W-1:0]   split_flag_mask_ff;
   logic [DATA_W-1:0]   seq_mask_ff;

   // frame state
   logic                half_pending_ff, half_pending_in;
   logic [CNT_W-1:0]    held_len_ff, held_len_in;
   logic [TIME_W-1:0]   held_time_ff, held_time_in;
   logic [CNT_W-1:0]    frame_count_ff, frame_count_in;
   mode_type            frame_mode_ff, frame_mode_in;
   logic                stale_seen_ff, stale_seen_in;
   logic [CNT_W-1:0]    stale_length_ff, stale_length_in;
   logic [DATA_W-1:0]   header_tag_ff, header_tag_in;
   logic [COUNT_W-1:0]  drop_total_ff, drop_total_in;
   logic [COUNT_W-1:0]  done_total_ff, done_total_in;

   // read stage
   logic                s1_valid_ff;
   logic [EVENT_W-1:0]  s1_event_ff, s1_event_in;
   logic [MAXLEN_W-1:0] s1_plen_ff, s1_plen_in;
   logic                s1_rd_ok_ff;

   // output register
   logic                out_valid_ff;
   logic [EVENT_W-1:0]  out_event_ff;
   logic                out_stale_ff;
   logic [MAXLEN_W-1:0] out_stale_size_ff;
   logic [MAXLEN_W-1:0] out_plen_ff;
   logic [DATA_W-1:0]   out_tag_ff;
   logic [DATA_W-1:0]   out_read_byte_ff;
   logic [COUNT_W-1:0]  out_drop_ff;
   logic [COUNT_W-1:0]  out_done_ff;

   logic                req_acc;
   logic                s1_move;
   logic                out_load;

   // store access
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic                rd_en;
   logic [DATA_W-1:0]   rd_data;
   logic [CMP_W-1:0]    ridx_w;
   logic                rd_ok;

   // helpers
   logic [TIME_W-1:0]   elapsed;
   logic                stale_now;
   logic                hp_hdr;
   logic [CNT_W-1:0]    hl_hdr;
   mode_type            mode_hdr;
   logic [CNT_W-1:0]    fc_step;
   logic [POS_W-1:0]    pos;
   logic                fin;
   mode_type            fin_mode;
   logic [CNT_W-1:0]    fin_fc;
   logic [CNT_W-1:0]    fin_hl;
   logic [CMP_W-1:0]    limit;
   logic [CMP_W-1:0]    total;
   logic [CMP_W-1:0]    plen_w;
   logic [CMP_W-1:0]    stale_w;
   logic                drop_inc;
   logic                done_inc;

   // handshake: stall only when both result registers are full and blocked
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_acc   = req_valid && !req_stall;

   assign ridx_w = CMP_W'(req_read_index);
   assign rd_ok  = ridx_w < CMP_W'(STORE_DEPTH);
   assign rd_en  = req_acc && (req_func == FUNC_READ) && rd_ok;

   assign elapsed   = req_now_ms - held_time_ff;
   assign stale_now = half_pending_ff && (elapsed > timeout_ms_ff);
   assign hp_hdr    = half_pending_ff && !stale_now;
   assign hl_hdr    = stale_now ? '0 : held_len_ff;
   assign fc_step   = frame_count_ff + CNT_W'(frame_count_ff <= CNT_W'(STORE_DEPTH));
   assign pos       = (frame_mode_ff == MODE_JOIN) ?
                      POS_W'(held_len_ff) + POS_W'(frame_count_ff) : POS_W'(frame_count_ff);
   assign wr_addr   = pos[ADDR_W-1:0];

   assign limit = (CMP_W'(join_limit_ff) < CMP_W'(STORE_DEPTH)) ?
                  CMP_W'(join_limit_ff) : CMP_W'(STORE_DEPTH);
   assign total = CMP_W'(fin_hl) + CMP_W'(fin_fc);

   always_comb begin
      if (hp_hdr) begin
         mode_hdr = MODE_JOIN;
      end else if ((req_data_byte & split_flag_mask_ff) != '0) begin
         mode_hdr = MODE_HOLD;
      end else begin
         mode_hdr = MODE_PLAIN;
      end
   end

   always_comb begin
      half_pending_in = half_pending_ff;
      held_len_in     = held_len_ff;
      held_time_in    = held_time_ff;
      frame_count_in  = frame_count_ff;
      frame_mode_in   = frame_mode_ff;
      stale_seen_in   = stale_seen_ff;
      stale_length_in = stale_length_ff;
      header_tag_in   = header_tag_ff;
      s1_event_in     = EV_BUSY;
      plen_w          = '0;
      wr_en           = 1'b0;
      fin             = 1'b0;
      fin_mode        = frame_mode_ff;
      fin_fc          = frame_count_ff;
      fin_hl          = held_len_ff;
      drop_inc        = 1'b0;
      done_inc        = 1'b0;

      if (req_acc) begin
         if (req_func == FUNC_READ) begin
            s1_event_in = EV_READ;
         end else if (req_first_of_frame) begin
            stale_seen_in   = stale_now;
            stale_length_in = stale_now ? held_len_ff : '0;
            drop_inc        = stale_now;
            half_pending_in = hp_hdr;
            held_len_in     = hl_hdr;
            header_tag_in   = req_data_byte & seq_mask_ff;
            frame_count_in  = '0;
            frame_mode_in   = mode_hdr;
            if (mode_hdr == MODE_HOLD) begin
               held_time_in = req_now_ms;
            end
            fin      = req_last_of_frame;
            fin_mode = mode_hdr;
            fin_fc   = '0;
            fin_hl   = hl_hdr;
         end else if (frame_mode_ff != MODE_IDLE) begin
            wr_en          = pos < POS_W'(STORE_DEPTH);
            frame_count_in = fc_step;
            fin            = req_last_of_frame;
            fin_fc         = fc_step;
         end
      end

      if (fin) begin
         unique case (fin_mode)
            MODE_PLAIN: begin
               if (fin_fc > CNT_W'(STORE_DEPTH)) begin
                  s1_event_in = EV_OVERFLOW;
               end else begin
                  s1_event_in = EV_COMPLETE;
                  plen_w      = CMP_W'(fin_fc);
                  done_inc    = 1'b1;
               end
            end
            MODE_HOLD: begin
               if (fin_fc > CNT_W'(STORE_DEPTH)) begin
                  s1_event_in     = EV_OVERFLOW;
                  half_pending_in = 1'b0;
                  held_len_in     = '0;
               end else begin
                  s1_event_in     = EV_HELD;
                  half_pending_in = 1'b1;
                  held_len_in     = fin_fc;
               end
            end
            MODE_JOIN: begin
               if (total > limit) begin
                  s1_event_in = EV_DROPPED;
                  drop_inc    = 1'b1;
               end else begin
                  s1_event_in = EV_COMPLETE;
                  plen_w      = total;
                  done_inc    = 1'b1;
               end
               half_pending_in = 1'b0;
               held_len_in     = '0;
            end
            MODE_IDLE: begin
               s1_event_in = EV_BUSY;
            end
         endcase
         frame_mode_in = MODE_IDLE;
      end

      drop_total_in = drop_total_ff + COUNT_W'(drop_inc);
      done_total_in = done_total_ff + COUNT_W'(done_inc);
      s1_plen_in    = plen_w[MAXLEN_W-1:0];
   end

   assign stale_w = CMP_W'(stale_length_ff);

   sfr_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (ridx_w[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         join_limit_ff      <= JOIN_LIMIT_RST;
         timeout_ms_ff      <= TIMEOUT_MS_RST;
         split_flag_mask_ff <= SPLIT_FLAG_MASK_RST;
         seq_mask_ff        <= SEQ_MASK_RST;
         half_pending_ff    <= 1'b0;
         held_len_ff        <= '0;
         held_time_ff       <= '0;
         frame_count_ff     <= '0;
         frame_mode_ff      <= MODE_PLAIN;
         stale_seen_ff      <= 1'b0;
         stale_length_ff    <= '0;
         header_tag_ff      <= '0;
         drop_total_ff      <= '0;
         done_total_ff      <= '0;
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_JOIN_LIMIT:      join_limit_ff      <= csr_wdata[MAXLEN_W-1:0];
               CSR_TIMEOUT_MS:      timeout_ms_ff      <= csr_wdata[TIME_W-1:0];
               CSR_SPLIT_FLAG_MASK: split_flag_mask_ff <= csr_wdata[DATA_W-1:0];
               CSR_SEQ_MASK:        seq_mask_ff        <= csr_wdata[DATA_W-1:0];
            endcase
         end
         half_pending_ff <= half_pending_in;
         held_len_ff     <= held_len_in;
         held_time_ff    <= held_time_in;
         frame_count_ff  <= frame_count_in;
         frame_mode_ff   <= frame_mode_in;
         stale_seen_ff   <= stale_seen_in;
         stale_length_ff <= stale_length_in;
         header_tag_ff   <= header_tag_in;
         drop_total_ff   <= drop_total_in;
         done_total_ff   <= done_total_in;
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_event_ff <= s1_event_in;
         s1_plen_ff  <= s1_plen_in;
         s1_rd_ok_ff <= rd_ok;
      end
      // state outputs reflect the latest transaction, which sits in the read stage
      if (s1_move) begin
         out_event_ff      <= s1_event_ff;
         out_plen_ff       <= s1_plen_ff;
         out_read_byte_ff  <= (s1_event_ff == EV_READ && s1_rd_ok_ff) ? rd_data : '0;
         out_stale_ff      <= stale_seen_ff;
         out_stale_size_ff <= stale_w[MAXLEN_W-1:0];
         out_tag_ff        <= header_tag_ff;
         out_drop_ff       <= drop_total_ff;
         out_done_ff       <= done_total_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_res       = out_event_ff;
   assign rsp_stale           = out_stale_ff;
   assign rsp_stale_size      = out_stale_size_ff;
   assign rsp_packet_len      = out_plen_ff;
   assign rsp_seq_tag         = out_tag_ff;
   assign rsp_read_byte       = out_read_byte_ff;
   assign rsp_dropped_count   = out_drop_ff;
   assign rsp_completed_count = out_done_ff;

   `SFR_ASSERT_NOW(a_held_len_clear, !half_pending_ff, held_len_ff == '0)
   `SFR_ASSERT_NOW(a_held_len_range, 1'b1, held_len_ff <= CNT_W'(STORE_DEPTH))
   `SFR_ASSERT_NEXT(a_result_kept, s1_valid_ff && out_valid_ff && rsp_stall, s1_valid_ff)
   `SFR_ASSERT_NEXT(a_done_step, 1'b1,
      done_total_ff == $past(done_total_ff) || done_total_ff == $past(done_total_ff) + 32'd1)

endmodule

// ----- hdl/sfr_store.sv -----
// ----------------------------------------------------------------------------
// sfr_store
// packet byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module sfr_store import sfr_pkg::*; #(
   parameter int DEPTH  = STORE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(STORE_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/reassembly_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reassembly_tb_pkg
// transaction types and the expected-result tracker for the split frame
// reassembler testbench
// ----------------------------------------------------------------------------
package reassembly_tb_pkg;
   import sfr_pkg::*;

   typedef enum logic [1:0] {
      FM_PLAIN,
      FM_FIRST_HALF,
      FM_PARTNER,
      FM_DONE
   } frame_mode_type;

   typedef struct packed {
      logic                    func;
      logic [DATA_W-1:0]       data_byte;
      logic                    frame_start;
      logic                    frame_end;
      logic [TIME_W-1:0]       now_ms;
      logic [READ_INDEX_W-1:0] read_index;
   } frame_req_type;

   typedef struct packed {
      logic [EVENT_W-1:0]  event_res;
      logic                stale;
      logic [MAXLEN_W-1:0] stale_size;
      logic [MAXLEN_W-1:0] packet_len;
      logic [DATA_W-1:0]   seq_tag;
      logic [DATA_W-1:0]   read_byte;
      logic [COUNT_W-1:0]  dropped_count;
      logic [COUNT_W-1:0]  completed_count;
   } frame_rsp_type;

   class reassembly_tracker;
      logic [MAXLEN_W-1:0] max_len;
      logic [TIME_W-1:0]   timeout;
      logic [DATA_W-1:0]   split_mask;
      logic [DATA_W-1:0]   seq_mask;

      logic [DATA_W-1:0]   store [STORE_DEPTH_DEF];
      int                  written_top;
      bit                  half_held;
      int                  held_len;
      logic [TIME_W-1:0]   held_time;
      int                  frame_len;
      frame_mode_type      mode;
      bit                  stale_seen;
      int                  retired_len;
      logic [DATA_W-1:0]   tag;
      logic [COUNT_W-1:0]  drops;
      logic [COUNT_W-1:0]  completions;

      frame_rsp_type       due_responses [$];
      int                  errors;

      function new();
         max_len     = JOIN_LIMIT_RST;
         timeout     = TIMEOUT_MS_RST;
         split_mask  = SPLIT_FLAG_MASK_RST;
         seq_mask    = SEQ_MASK_RST;
         foreach (store[i]) store[i] = '0;
         written_top = 0;
         half_held   = 1'b0;
         held_len    = 0;
         held_time   = '0;
         frame_len   = 0;
         mode        = FM_PLAIN;
         stale_seen  = 1'b0;
         retired_len = 0;
         tag         = '0;
         drops       = '0;
         completions = '0;
         errors      = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_JOIN_LIMIT:      max_len = val[MAXLEN_W-1:0];
            CSR_TIMEOUT_MS:      timeout = val[TIME_W-1:0];
            CSR_SPLIT_FLAG_MASK: split_mask = val[DATA_W-1:0];
            CSR_SEQ_MASK:        seq_mask = val[DATA_W-1:0];
            default: ;
         endcase
      endfunction

      function void close_frame(output logic [EVENT_W-1:0] ev,
                                output logic [MAXLEN_W-1:0] plen);
         int cap;
         int joined;
         ev   = EV_BUSY;
         plen = '0;
         case (mode)
            FM_PLAIN: begin
               if (frame_len > STORE_DEPTH_DEF) begin
                  ev = EV_OVERFLOW;
               end else begin
                  ev = EV_COMPLETE;
                  plen = MAXLEN_W'(frame_len);
                  completions++;
               end
            end
            FM_FIRST_HALF: begin
               if (frame_len > STORE_DEPTH_DEF) begin
                  ev = EV_OVERFLOW;
                  half_held = 1'b0;
                  held_len = 0;
               end else begin
                  ev = EV_HELD;
                  half_held = 1'b1;
                  held_len = frame_len;
               end
            end
            FM_PARTNER: begin
               // join limit never exceeds the store
               cap = (max_len < STORE_DEPTH_DEF) ? int'(max_len) : STORE_DEPTH_DEF;
               joined = held_len + frame_len;
               if (joined > cap) begin
                  ev = EV_DROPPED;
                  drops++;
               end else begin
                  ev = EV_COMPLETE;
                  plen = MAXLEN_W'(joined);
                  completions++;
               end
               half_held = 1'b0;
               held_len = 0;
            end
            default: ;
         endcase
         mode = FM_DONE;
      endfunction

      function void take_request(frame_req_type r);
         frame_rsp_type       e;
         logic [EVENT_W-1:0]  ev;
         logic [MAXLEN_W-1:0] plen;
         logic [TIME_W-1:0]   age;
         int                  pos;
         e    = '0;
         ev   = EV_BUSY;
         plen = '0;
         if (r.func == FUNC_READ) begin
            ev = EV_READ;
            e.read_byte = store[r.read_index];
         end else if (r.frame_start) begin
            age = r.now_ms - held_time;
            if (half_held && age > timeout) begin
               stale_seen = 1'b1;
               retired_len = held_len;
               drops++;
               half_held = 1'b0;
               held_len = 0;
            end else begin
               stale_seen = 1'b0;
               retired_len = 0;
            end
            tag = r.data_byte & seq_mask;
            frame_len = 0;
            // a held half claims the next frame whatever its header says
            if (half_held) begin
               mode = FM_PARTNER;
            end else if ((r.data_byte & split_mask) != '0) begin
               mode = FM_FIRST_HALF;
               held_time = r.now_ms;
            end else begin
               mode = FM_PLAIN;
            end
            if (r.frame_end) close_frame(ev, plen);
         end else if (mode != FM_DONE) begin
            pos = (mode == FM_PARTNER) ? held_len + frame_len : frame_len;
            if (pos < STORE_DEPTH_DEF) begin
               store[pos] = r.data_byte;
               if (pos >= written_top) written_top = pos + 1;
            end
            if (frame_len <= STORE_DEPTH_DEF) frame_len++;
            if (r.frame_end) close_frame(ev, plen);
         end
         e.event_res       = ev;
         e.stale           = stale_seen;
         e.stale_size      = MAXLEN_W'(retired_len);
         e.packet_len      = plen;
         e.seq_tag         = tag;
         e.dropped_count   = drops;
         e.completed_count = completions;
         due_responses.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_response(frame_rsp_type got);
         frame_rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: response with no request waiting, event_res %0d",
                     $time, got.event_res);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
         compare_field("stale", 32'(want.stale), 32'(got.stale));
         compare_field("stale_size", 32'(want.stale_size), 32'(got.stale_size));
         compare_field("packet_len", 32'(want.packet_len), 32'(got.packet_len));
         compare_field("seq_tag", 32'(want.seq_tag), 32'(got.seq_tag));
         compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
         compare_field("dropped_count", want.dropped_count, got.dropped_count);
         compare_field("completed_count", want.completed_count, got.completed_count);
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// byte-stream test of the split frame reassembler: directed frames, random
// well-formed and broken frame sequences, a long frame and store reads under
// several register settings, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
   import sfr_pkg::*;
   import reassembly_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_func;
   logic [DATA_W-1:0]       req_data_byte;
   logic                    req_first_of_frame;
   logic                    req_last_of_frame;
   logic [TIME_W-1:0]       req_now_ms;
   logic [READ_INDEX_W-1:0] req_read_index;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [EVENT_W-1:0]      rsp_event_res;
   logic                    rsp_stale;
   logic [MAXLEN_W-1:0]     rsp_stale_size;
   logic [MAXLEN_W-1:0]     rsp_packet_len;
   logic [DATA_W-1:0]       rsp_seq_tag;
   logic [DATA_W-1:0]       rsp_read_byte;
   logic [COUNT_W-1:0]      rsp_dropped_count;
   logic [COUNT_W-1:0]      rsp_completed_count;

   reassembly_tracker tracker;
   int                cycle_count = 0;
   int                burst_left;
   bit                gaps_on;
   logic [TIME_W-1:0] wall_ms;

   split_frame_reassembler DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   // result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_response({rsp_event_res, rsp_stale, rsp_stale_size, rsp_packet_len,
                                 rsp_seq_tag, rsp_read_byte, rsp_dropped_count,
                                 rsp_completed_count});
   end

   initial begin : rsp_pacing
      int style;
      int span;
      int k;
      rsp_stall = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(16, 160);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            case (style)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 99) < 30);
               2: rsp_stall = ((k % 5) < 3);
               default: rsp_stall = ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_item(input frame_req_type r);
      if (gaps_on && burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_func           = r.func;
      req_data_byte      = r.data_byte;
      req_first_of_frame = r.frame_start;
      req_last_of_frame  = r.frame_end;
      req_now_ms         = r.now_ms;
      req_read_index     = r.read_index;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.take_request(r);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [DATA_W-1:0] data, input logic sof, input logic eof,
                            input logic [TIME_W-1:0] now);
      frame_req_type r;
      r.func        = FUNC_PUSH;
      r.data_byte   = data;
      r.frame_start = sof;
      r.frame_end   = eof;
      r.now_ms      = now;
      r.read_index  = READ_INDEX_W'($urandom_range(0, 511));
      send_item(r);
   endtask

   task automatic read_at(input int idx);
      frame_req_type r;
      r.func        = FUNC_READ;
      r.data_byte   = DATA_W'($urandom_range(0, 255));
      r.frame_start = 1'($urandom_range(0, 1));
      r.frame_end   = 1'($urandom_range(0, 1));
      r.now_ms      = $urandom;
      r.read_index  = READ_INDEX_W'(idx);
      send_item(r);
   endtask

   // written entries always form a prefix of the store
   task automatic read_some();
      int top;
      top = tracker.written_top;
      if (top > 0) begin
         case ($urandom_range(0, 3))
            0: read_at(top - 1);
            1: read_at(0);
            default: read_at($urandom_range(0, top - 1));
         endcase
      end
   endtask

   function automatic logic [TIME_W-1:0] advance_wall_ms();
      logic [TIME_W-1:0] step;
      case ($urandom_range(0, 9))
         6: step = tracker.timeout;
         7: step = tracker.timeout + 1;
         8: step = tracker.timeout - 1;
         9: step = $urandom;
         default: step = $urandom_range(0, 40);
      endcase
      wall_ms = wall_ms + step;
      return wall_ms;
   endfunction

   task automatic send_frame(input bit split, input int len, input bit broken);
      logic [DATA_W-1:0] hdr;
      int                i;
      hdr = DATA_W'($urandom_range(0, 255));
      hdr = split ? (hdr | tracker.split_mask) : (hdr & ~tracker.split_mask);
      push_byte(hdr, 1'b1, (len == 0) && !broken, advance_wall_ms());
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) read_some();
         push_byte(DATA_W'($urandom_range(0, 255)), 1'b0, (i == len - 1) && !broken,
                   $urandom);
      end
   endtask

   task automatic run_random(input int target);
      int count;
      int pick;
      int n;
      int len;
      count = 0;
      while (count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // payload with no header: ignored unless a frame is still open
            repeat ($urandom_range(1, 3))
               push_byte(DATA_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                         $urandom);
         end else if (pick < 20) begin
            n = $urandom_range(1, 3);
            repeat (n) read_some();
            count += n;
         end else begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            send_frame($urandom_range(0, 99) < 45, len, $urandom_range(0, 99) < 8);
            count += len + 1;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      tracker.set_register(idx, val);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] max_len, input logic [CSR_DATA_W-1:0] tmo,
                             input logic [CSR_DATA_W-1:0] split_mask,
                             input logic [CSR_DATA_W-1:0] seq_mask);
      write_reg(CSR_JOIN_LIMIT, max_len);
      write_reg(CSR_TIMEOUT_MS, tmo);
      write_reg(CSR_SPLIT_FLAG_MASK, split_mask);
      write_reg(CSR_SEQ_MASK, seq_mask);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      tracker            = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_JOIN_LIMIT;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_func           = FUNC_PUSH;
      req_data_byte      = '0;
      req_first_of_frame = 1'b0;
      req_last_of_frame  = 1'b0;
      req_now_ms         = '0;
      req_read_index     = '0;
      burst_left         = 0;
      gaps_on            = 1'b1;
      wall_ms            = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part under reset register values
      push_byte(8'h00, 1'b0, 1'b0, 32'd0);          // bytes after reset form a plain frame
      push_byte(8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
      push_byte(8'h5A, 1'b0, 1'b0, 32'd0);          // outside any frame
      read_at(0);
      read_at(1);
      push_byte(8'hFF, 1'b1, 1'b1, 32'd100);        // empty first half
      push_byte(8'h00, 1'b1, 1'b0, 32'd200);
      push_byte(8'hA5, 1'b0, 1'b1, 32'd0);
      push_byte(8'h81, 1'b1, 1'b0, 32'd300);
      push_byte(8'h11, 1'b0, 1'b0, 32'd0);
      push_byte(8'h22, 1'b0, 1'b1, 32'd0);
      push_byte(8'h30, 1'b1, 1'b0, 32'd1300);       // age equals timeout: still joins
      push_byte(8'h33, 1'b0, 1'b0, 32'd0);
      push_byte(8'h40, 1'b1, 1'b0, 32'd1300);       // abandons the partner, half stays held
      push_byte(8'h44, 1'b0, 1'b1, 32'd0);
      push_byte(8'h01, 1'b1, 1'b0, 32'd2000);
      push_byte(8'h55, 1'b0, 1'b1, 32'd0);
      push_byte(8'hE0, 1'b1, 1'b1, 32'd3001);       // held half goes stale
      push_byte(8'h03, 1'b1, 1'b0, 32'd3001);
      push_byte(8'h66, 1'b0, 1'b0, 32'd0);
      push_byte(8'h02, 1'b1, 1'b1, 32'd3002);       // abandons the first half
      read_at(2);
      read_at(0);
      drain();

      set_config(32'd1023, 32'd0, 32'hFF, 32'hFF);
      wall_ms = $urandom;
      run_random(25);
      drain();

      set_config(32'd1, 32'd7, 32'h0F, 32'h00);
      gaps_on = 1'b0;
      run_random(15);
      drain();

      set_config(32'd20, 32'd30, 32'h80, 32'h0F);
      gaps_on = 1'b1;
      wall_ms = 32'hFFFF_FF00;
      run_random(25);
      drain();

      // long first half: store overflow, nothing is held afterwards
      set_config(32'd1023, 32'hFFFF_FFFF, 32'h01, 32'hF0);
      send_frame(1'b0, 0, 1'b0);                     // retires any half still held
      send_frame(1'b1, 513, 1'b0);
      send_frame(1'b0, 3, 1'b0);
      repeat (6) read_some();
      drain();

      set_config($urandom_range(1, 512), $urandom, $urandom_range(1, 255),
                 $urandom_range(0, 255));
      run_random(15);
      drain();

      set_config(32'd512, 32'd1000, 32'h00, 32'hAA);
      run_random(10);
      drain();

      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
